// File: design/zscore_peak_detector_macros.svh
// ----------------------------------------------------------------------------
// zscore_peak_detector_macros.svh
// Assertion macros used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ZSCORE_PEAK_DETECTOR_MACROS_SVH
`define ZSCORE_PEAK_DETECTOR_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ZPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ZPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/zpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpd_pkg
// Shared constants, codes and types of the z-score peak detector.
// ----------------------------------------------------------------------------
package zpd_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int LEN_BITS      = 7;
    localparam int THR_BITS      = 16;
    localparam int INF_BITS      = 17;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;

    localparam int LEN_RESET = 30;
    localparam int LEN_MIN   = 2;
    localparam int THR_RESET = 1280;
    localparam int INF_RESET = 0;
    localparam int INF_ONE   = 65536;

    // digit-serial multiplier: B operand consumed 16 bits per step
    localparam int DIGIT_BITS = 16;
    localparam int MUL_DIGITS = 3;
    localparam int MUL_B_BITS = DIGIT_BITS * MUL_DIGITS;

    localparam logic [1:0] PEAK_NONE = 2'b00;
    localparam logic [1:0] PEAK_POS  = 2'b01;
    localparam logic [1:0] PEAK_NEG  = 2'b11;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_THRESHOLD     = 2'd1,
        REG_INFLUENCE     = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DSQ,
        ST_LHS,
        ST_LSQ,
        ST_SSQ,
        ST_TT,
        ST_TL,
        ST_RHS,
        ST_CMP,
        ST_BLEND,
        ST_SQO,
        ST_SQF,
        ST_WB
    } state_t;

endpackage

// File: design/zscore_peak_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zscore_peak_detector
// Smoothed z-score peak detector over a sliding window held in block RAM.
// ----------------------------------------------------------------------------
// One sample is processed at a time; s_ready is high only while the sequencer
// is idle. A warm-up sample takes one squaring plus write-back. A sample past
// warm-up sends nine products through the shared digit-serial multiplier, each
// in 3 digit steps plus start and capture, and adds the window read, compare,
// blend (on a peak only) and write-back steps. The result sits in an output
// register, so the next sample is taken while it waits; write-back stalls only
// if that register is still full. The window store needs no clearing at reset:
// an entry is read only after it was written in the current block.
// ----------------------------------------------------------------------------
module zscore_peak_detector #(
    parameter int MAX_WINDOW  = zpd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = zpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample,
    input  logic                               s_block_start,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [1:0]                  m_peak_signal,
    output logic                               m_window_ready,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [zpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [zpd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // filtered value, Q16.8 style with SAMPLE_BITS integer bits
    localparam int FW   = SAMPLE_BITS + 8;
    localparam int LW   = zpd_pkg::LEN_BITS;
    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int SUMW = FW + 7;          // sum of up to 127 values
    localparam int SQW  = 2 * FW + 5;      // sum of their squares
    localparam int DW   = FW + 8;          // L*x - sum
    localparam int MW   = FW + 7;          // |L*x - sum|
    localparam int VW   = 2 * FW + 12;     // L*sumsq - sum^2
    localparam int MAW  = 2 * FW + 14;     // multiplier A width
    localparam int MBW  = zpd_pkg::MUL_B_BITS;
    localparam int PW   = MAW + MBW;
    localparam int CW   = 2 * FW + 51;     // both sides of the squared test
    localparam int TTW  = 2 * zpd_pkg::THR_BITS;
    localparam int TLW  = TTW + LW;
    localparam int INW  = zpd_pkg::INF_BITS;

    zpd_pkg::state_t state_reg, state_next;

    // configuration
    logic [LW-1:0]                 len_reg, len_next;
    logic [zpd_pkg::THR_BITS-1:0]  thr_reg, thr_next;
    logic [INW-1:0]                inf_reg, inf_next;

    // block state
    logic [AW-1:0]                 slot_reg, slot_next;
    logic [LW-1:0]                 fill_reg, fill_next;
    logic signed [SUMW-1:0]        sum_reg, sum_next;
    logic [SQW-1:0]                sq_reg, sq_next;
    logic signed [FW-1:0]          last_reg, last_next;

    // per-sample work registers
    logic signed [FW-1:0]          x_reg, x_next;
    logic signed [FW-1:0]          f_reg, f_next;
    logic                          full_reg, full_next;
    logic [1:0]                    sig_reg, sig_next;
    logic signed [DW-1:0]          d_reg, d_next;
    logic [2*MW-1:0]               dsq_reg, dsq_next;
    logic [CW-1:0]                 lhs_reg, lhs_next;
    logic [VW-1:0]                 var_reg, var_next;
    logic [TTW-1:0]                tt_reg, tt_next;
    logic [TLW-1:0]                tl_reg, tl_next;
    logic [CW-1:0]                 rhs_reg, rhs_next;
    logic [SQW-1:0]                sqo_reg, sqo_next;
    logic [SQW-1:0]                sqf_reg, sqf_next;
    logic                          issued_reg, issued_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [1:0]                    m_peak_reg, m_peak_next;
    logic                          m_wready_reg, m_wready_next;

    // memory and multiplier hookup
    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [FW-1:0]                 ram_rdata;
    logic signed [FW-1:0]          old_val;
    logic                          mul_start, mul_done;
    logic [MAW-1:0]                mul_a;
    logic [MBW-1:0]                mul_b;
    logic [PW-1:0]                 mul_prod;

    // helpers
    logic                          accept, out_free, is_mul, warm;
    logic [MW-1:0]                 d_mag;
    logic [SUMW-1:0]               sum_mag;
    logic [FW-1:0]                 old_mag, f_mag;
    logic signed [DW-1:0]          d_calc;
    logic signed [FW:0]            bl_diff;
    logic signed [FW+18:0]         bl_prod;
    logic signed [FW+2:0]          bl_step;
    logic [LW-1:0]                 cfg_len;
    int                            rd_idx;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign old_val  = ram_rdata;

    assign is_mul = (state_reg == zpd_pkg::ST_DSQ) || (state_reg == zpd_pkg::ST_LHS)
                 || (state_reg == zpd_pkg::ST_LSQ) || (state_reg == zpd_pkg::ST_SSQ)
                 || (state_reg == zpd_pkg::ST_TT)  || (state_reg == zpd_pkg::ST_TL)
                 || (state_reg == zpd_pkg::ST_RHS) || (state_reg == zpd_pkg::ST_SQO)
                 || (state_reg == zpd_pkg::ST_SQF);

    // magnitudes for the unsigned multiplier
    assign d_mag   = d_reg[DW-1] ? MW'(-d_reg) : MW'(d_reg);
    assign sum_mag = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    assign old_mag = old_val[FW-1] ? FW'(-old_val) : FW'(old_val);
    assign f_mag   = f_reg[FW-1] ? FW'(-f_reg) : FW'(f_reg);

    // oldest entry of the window; equals the write slot when L == depth,
    // which is fine since the read happens before this sample's write
    always_comb begin
        rd_idx = int'(slot_reg) - int'(len_reg);
        if (rd_idx < 0) begin
            rd_idx = rd_idx + MAX_WINDOW;
        end
        ram_raddr = AW'(rd_idx);
    end

    assign d_calc = DW'($signed({1'b0, len_reg})) * DW'(x_reg) - DW'(sum_reg);

    // blend: last + round(inf * (x - last) / 2^16)
    always_comb begin
        bl_diff = (FW+1)'(x_reg) - (FW+1)'(last_reg);
        bl_prod = (FW+19)'($signed({1'b0, inf_reg})) * (FW+19)'(bl_diff)
                + (FW+19)'(32768);
        bl_step = bl_prod[FW+18:16];
    end

    assign warm = s_block_start || (fill_reg < len_reg);

    // clamp of a window_length write
    always_comb begin
        cfg_len = cfg_data[LW-1:0];
        if (cfg_len < LW'(zpd_pkg::LEN_MIN)) begin
            cfg_len = LW'(zpd_pkg::LEN_MIN);
        end else if (int'(cfg_len) > MAX_WINDOW) begin
            cfg_len = LW'(MAX_WINDOW);
        end
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            zpd_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = warm ? zpd_pkg::ST_SQF : zpd_pkg::ST_READ;
                end
            end
            zpd_pkg::ST_READ:  state_next = zpd_pkg::ST_DSQ;
            zpd_pkg::ST_DSQ:   if (mul_done) state_next = zpd_pkg::ST_LHS;
            zpd_pkg::ST_LHS:   if (mul_done) state_next = zpd_pkg::ST_LSQ;
            zpd_pkg::ST_LSQ:   if (mul_done) state_next = zpd_pkg::ST_SSQ;
            zpd_pkg::ST_SSQ:   if (mul_done) state_next = zpd_pkg::ST_TT;
            zpd_pkg::ST_TT:    if (mul_done) state_next = zpd_pkg::ST_TL;
            zpd_pkg::ST_TL:    if (mul_done) state_next = zpd_pkg::ST_RHS;
            zpd_pkg::ST_RHS:   if (mul_done) state_next = zpd_pkg::ST_CMP;
            zpd_pkg::ST_CMP: begin
                state_next = (lhs_reg > rhs_reg) ? zpd_pkg::ST_BLEND : zpd_pkg::ST_SQO;
            end
            zpd_pkg::ST_BLEND: state_next = zpd_pkg::ST_SQO;
            zpd_pkg::ST_SQO:   if (mul_done) state_next = zpd_pkg::ST_SQF;
            zpd_pkg::ST_SQF:   if (mul_done) state_next = zpd_pkg::ST_WB;
            zpd_pkg::ST_WB:    if (out_free) state_next = zpd_pkg::ST_IDLE;
            default:           state_next = zpd_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs: handshake, memory strobes, multiplier operands
    // ------------------------------------------------------------------
    always_comb begin
        s_ready   = (state_reg == zpd_pkg::ST_IDLE);
        ram_re    = (state_reg == zpd_pkg::ST_READ);
        ram_we    = (state_reg == zpd_pkg::ST_WB) && out_free;
        mul_start = is_mul && !issued_reg;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            zpd_pkg::ST_DSQ: begin
                mul_a = MAW'(d_mag);
                mul_b = MBW'(d_mag);
            end
            zpd_pkg::ST_LHS: begin
                mul_a = MAW'(dsq_reg);
                mul_b = MBW'({len_reg - 1'b1, 16'b0});
            end
            zpd_pkg::ST_LSQ: begin
                mul_a = MAW'(sq_reg);
                mul_b = MBW'(len_reg);
            end
            zpd_pkg::ST_SSQ: begin
                mul_a = MAW'(sum_mag);
                mul_b = MBW'(sum_mag);
            end
            zpd_pkg::ST_TT: begin
                mul_a = MAW'(thr_reg);
                mul_b = MBW'(thr_reg);
            end
            zpd_pkg::ST_TL: begin
                mul_a = MAW'(tt_reg);
                mul_b = MBW'(len_reg);
            end
            zpd_pkg::ST_RHS: begin
                mul_a = MAW'(var_reg);
                mul_b = MBW'(tl_reg);
            end
            zpd_pkg::ST_SQO: begin
                mul_a = MAW'(old_mag);
                mul_b = MBW'(old_mag);
            end
            zpd_pkg::ST_SQF: begin
                mul_a = MAW'(f_mag);
                mul_b = MBW'(f_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_comb begin
        len_next      = len_reg;
        thr_next      = thr_reg;
        inf_next      = inf_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        last_next     = last_reg;
        x_next        = x_reg;
        f_next        = f_reg;
        full_next     = full_reg;
        sig_next      = sig_reg;
        d_next        = d_reg;
        dsq_next      = dsq_reg;
        lhs_next      = lhs_reg;
        var_next      = var_reg;
        tt_next       = tt_reg;
        tl_next       = tl_reg;
        rhs_next      = rhs_reg;
        sqo_next      = sqo_reg;
        sqf_next      = sqf_reg;
        m_peak_next   = m_peak_reg;
        m_wready_next = m_wready_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (mul_start) begin
            issued_next = 1'b1;
        end else if (mul_done) begin
            issued_next = 1'b0;
        end else begin
            issued_next = issued_reg;
        end

        // the user must make config writes only while idle; nothing in the block enforces it
        if (cfg_we) begin
            unique case (cfg_index)
                zpd_pkg::REG_WINDOW_LENGTH: begin
                    len_next  = cfg_len;
                    slot_next = '0;
                    fill_next = '0;
                    sum_next  = '0;
                    sq_next   = '0;
                    last_next = '0;
                end
                zpd_pkg::REG_THRESHOLD: thr_next = cfg_data[zpd_pkg::THR_BITS-1:0];
                zpd_pkg::REG_INFLUENCE: begin
                    inf_next = (cfg_data > INW'(zpd_pkg::INF_ONE))
                             ? INW'(zpd_pkg::INF_ONE) : cfg_data;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            zpd_pkg::ST_IDLE: begin
                if (accept) begin
                    x_next    = {s_sample, 8'b0};
                    f_next    = {s_sample, 8'b0};
                    full_next = !warm;
                    sig_next  = zpd_pkg::PEAK_NONE;
                    if (s_block_start) begin
                        slot_next = '0;
                        fill_next = '0;
                        sum_next  = '0;
                        sq_next   = '0;
                        last_next = '0;
                    end
                end
            end
            zpd_pkg::ST_READ: d_next = d_calc;
            zpd_pkg::ST_DSQ:  if (mul_done) dsq_next = mul_prod[2*MW-1:0];
            zpd_pkg::ST_LHS:  if (mul_done) lhs_next = mul_prod[CW-1:0];
            zpd_pkg::ST_LSQ:  if (mul_done) var_next = mul_prod[VW-1:0];
            zpd_pkg::ST_SSQ:  if (mul_done) var_next = var_reg - mul_prod[VW-1:0];
            zpd_pkg::ST_TT:   if (mul_done) tt_next  = mul_prod[TTW-1:0];
            zpd_pkg::ST_TL:   if (mul_done) tl_next  = mul_prod[TLW-1:0];
            zpd_pkg::ST_RHS:  if (mul_done) rhs_next = mul_prod[CW-1:0];
            zpd_pkg::ST_CMP: begin
                // d is never zero when the test fires
                if (lhs_reg > rhs_reg) begin
                    sig_next = d_reg[DW-1] ? zpd_pkg::PEAK_NEG : zpd_pkg::PEAK_POS;
                end
            end
            zpd_pkg::ST_BLEND: f_next = FW'((FW+3)'(last_reg) + bl_step);
            zpd_pkg::ST_SQO:  if (mul_done) sqo_next = mul_prod[SQW-1:0];
            zpd_pkg::ST_SQF:  if (mul_done) sqf_next = mul_prod[SQW-1:0];
            zpd_pkg::ST_WB: begin
                if (out_free) begin
                    if (full_reg) begin
                        sum_next = sum_reg - SUMW'(old_val) + SUMW'(f_reg);
                        sq_next  = sq_reg - sqo_reg + sqf_reg;
                    end else begin
                        sum_next  = sum_reg + SUMW'(f_reg);
                        sq_next   = sq_reg + sqf_reg;
                        fill_next = fill_reg + 1'b1;
                    end
                    slot_next     = (int'(slot_reg) == MAX_WINDOW - 1) ? '0 : slot_reg + 1'b1;
                    last_next     = f_reg;
                    m_valid_next  = 1'b1;
                    m_peak_next   = sig_reg;
                    m_wready_next = full_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= zpd_pkg::ST_IDLE;
            len_reg     <= LW'(zpd_pkg::LEN_RESET < MAX_WINDOW ? zpd_pkg::LEN_RESET
                                                                : MAX_WINDOW);
            thr_reg     <= zpd_pkg::THR_BITS'(zpd_pkg::THR_RESET);
            inf_reg     <= INW'(zpd_pkg::INF_RESET);
            slot_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            last_reg    <= '0;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            thr_reg     <= thr_next;
            inf_reg     <= inf_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            last_reg    <= last_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        f_reg        <= f_next;
        full_reg     <= full_next;
        sig_reg      <= sig_next;
        d_reg        <= d_next;
        dsq_reg      <= dsq_next;
        lhs_reg      <= lhs_next;
        var_reg      <= var_next;
        tt_reg       <= tt_next;
        tl_reg       <= tl_next;
        rhs_reg      <= rhs_next;
        sqo_reg      <= sqo_next;
        sqf_reg      <= sqf_next;
        m_peak_reg   <= m_peak_next;
        m_wready_reg <= m_wready_next;
    end

    zpd_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (FW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (f_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    zpd_mul #(
        .A_BITS (MAW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    assign m_valid        = m_valid_reg;
    assign m_peak_signal  = m_peak_reg;
    assign m_window_ready = m_wready_reg;

endmodule

// File: design/zpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpd_ram
// Window store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module zpd_ram #(
    parameter int DEPTH = zpd_pkg::MAX_WINDOW_DEF,
    parameter int WIDTH = zpd_pkg::SAMPLE_BITS_DEF + 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/zpd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpd_mul
// Unsigned digit-serial multiplier: A times one 16-bit digit of B per cycle.
// ----------------------------------------------------------------------------
module zpd_mul #(
    parameter int A_BITS = 2 * (zpd_pkg::SAMPLE_BITS_DEF + 8) + 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [A_BITS-1:0]                     a,
    input  logic [zpd_pkg::MUL_B_BITS-1:0]        b,
    output logic                                  done,
    output logic [A_BITS+zpd_pkg::MUL_B_BITS-1:0] prod
);

    localparam int DB = zpd_pkg::DIGIT_BITS;
    localparam int BB = zpd_pkg::MUL_B_BITS;
    localparam int CB = $clog2(zpd_pkg::MUL_DIGITS);

    logic [A_BITS-1:0]  a_reg;
    logic [BB-1:0]      b_reg, b_next;
    logic [A_BITS:0]    hi_reg, hi_next;
    logic [BB-1:0]      lo_reg, lo_next;
    logic [CB-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [A_BITS+DB:0] step_sum;

    always_comb begin
        step_sum  = (A_BITS+DB+1)'(hi_reg) + (A_BITS+DB+1)'(a_reg * b_reg[DB-1:0]);
        b_next    = b_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            b_next    = b;
            hi_next   = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            lo_next  = {step_sum[DB-1:0], lo_reg[BB-1:DB]};
            hi_next  = step_sum[A_BITS+DB:DB];
            b_next   = b_reg >> DB;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CB'(zpd_pkg::MUL_DIGITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
        end
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg[A_BITS-1:0], lo_reg};

endmodule

// File: design/zpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpd_port_checker
// Port-level checks on the result channel of the peak detector.
// ----------------------------------------------------------------------------
`include "zscore_peak_detector_macros.svh"

module zpd_port_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_peak_signal,
    input logic       m_window_ready
);

    `ZPD_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_peak_signal) && $stable(m_window_ready), "result changed while stalled")

    `ZPD_ASSERT(a_peak_code, m_valid |-> (m_peak_signal == zpd_pkg::PEAK_NONE) || (m_peak_signal == zpd_pkg::PEAK_POS) || (m_peak_signal == zpd_pkg::PEAK_NEG), "illegal peak code")

    `ZPD_ASSERT(a_warm_quiet, m_valid && !m_window_ready |-> m_peak_signal == zpd_pkg::PEAK_NONE, "peak during warm-up")

    `ZPD_ASSERT_ALWAYS(a_reset_idle, $past(!aresetn) |-> !m_valid, "result valid after reset")

endmodule

bind zscore_peak_detector zpd_port_checker u_zpd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_peak_signal  (m_peak_signal),
    .m_window_ready (m_window_ready)
);

// File: verif/zpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpd_checker
// Watches the sample, result and configuration ports of the z-score peak
// detector, predicts each result and compares it with what the block returns.
// ----------------------------------------------------------------------------
module zpd_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [15:0]                s_sample,
    input  logic                              s_block_start,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [1:0]                 m_peak_signal,
    input  logic                              m_window_ready,
    input  logic                              cfg_we,
    input  logic [zpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [zpd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                fail_count,
    output int                                pending
);

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [1:0] peak;
        logic       ready;
    } peak_result_t;

    peak_result_t expected_peaks[$];

    longint       win_vals[DEPTH];
    int           slot;
    int           fill;
    longint       win_sum;
    logic [127:0] win_sq_sum;
    longint       prev_filt;
    int           cur_len;
    int           cur_thr;
    int           cur_inf;

    function automatic logic [127:0] square_mag(longint v);
        logic [127:0] m;
        m = (v < 0) ? 128'(-v) : 128'(v);
        return m * m;
    endfunction

    function automatic void clear_window();
        slot       = 0;
        fill       = 0;
        win_sum    = 0;
        win_sq_sum = '0;
        prev_filt  = 0;
    endfunction

    // exact integer form of |s - mean| > k * sd, both sides squared
    function automatic peak_result_t detect(logic signed [15:0] smp, logic bs);
        peak_result_t r;
        longint       x, f, d, oldest, mix;
        logic [127:0] lhs, rhs, spread, dm;
        if (bs)
            clear_window();
        x = longint'(smp) * 256;
        f = x;
        r.peak  = zpd_pkg::PEAK_NONE;
        r.ready = 1'b0;
        if (fill >= cur_len) begin
            d      = longint'(cur_len) * x - win_sum;
            dm     = (d < 0) ? 128'(-d) : 128'(d);
            lhs    = dm * dm * 128'(longint'(cur_len - 1) * 65536);
            spread = 128'(cur_len) * win_sq_sum - square_mag(win_sum);
            rhs    = 128'(cur_thr) * 128'(cur_thr) * 128'(cur_len) * spread;
            oldest = win_vals[(slot + DEPTH - cur_len) % DEPTH];
            r.ready = 1'b1;
            if (lhs > rhs) begin
                r.peak = (d > 0) ? zpd_pkg::PEAK_POS : zpd_pkg::PEAK_NEG;
                mix = longint'(cur_inf) * x
                    + longint'(zpd_pkg::INF_ONE - cur_inf) * prev_filt + 32768;
                f = mix >>> 16;  // floor, so ties round up
            end
            win_sum    -= oldest;
            win_sq_sum -= square_mag(oldest);
        end else begin
            fill++;
        end
        win_sum    += f;
        win_sq_sum += square_mag(f);
        win_vals[slot] = f;
        slot      = (slot + 1) % DEPTH;
        prev_filt = f;
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("%0t zpd_checker: %s mismatch, expected %0d got %0d", $time, what, want, got);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        peak_result_t want;
        if (!aresetn) begin
            expected_peaks.delete();
            clear_window();
            cur_len = zpd_pkg::LEN_RESET;
            cur_thr = zpd_pkg::THR_RESET;
            cur_inf = zpd_pkg::INF_RESET;
        end else begin
            // results first: a returned result always belongs to an earlier sample
            if (m_valid && m_ready) begin
                if (expected_peaks.size() == 0) begin
                    report_mismatch("unexpected result", 0, 1);
                end else begin
                    want = expected_peaks.pop_front();
                    if (m_peak_signal !== want.peak)
                        report_mismatch("peak_signal", $signed(want.peak), $signed(m_peak_signal));
                    if (m_window_ready !== want.ready)
                        report_mismatch("window_ready", want.ready, m_window_ready);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    zpd_pkg::REG_WINDOW_LENGTH: begin
                        cur_len = int'(cfg_data[zpd_pkg::LEN_BITS-1:0]);
                        if (cur_len < zpd_pkg::LEN_MIN)
                            cur_len = zpd_pkg::LEN_MIN;
                        if (cur_len > DEPTH)
                            cur_len = DEPTH;
                        clear_window();
                    end
                    zpd_pkg::REG_THRESHOLD:
                        cur_thr = int'(cfg_data[zpd_pkg::THR_BITS-1:0]);
                    zpd_pkg::REG_INFLUENCE:
                        cur_inf = (cfg_data > zpd_pkg::INF_ONE) ? zpd_pkg::INF_ONE
                                                                : int'(cfg_data);
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_peaks.push_back(detect(s_sample, s_block_start));
        end
        pending <= expected_peaks.size();
    end

endmodule

// File: verif/tb_zscore_peak_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zscore_peak_detector
// Drives samples and register writes into the z-score peak detector, with
// bursty input and a stalling result side; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_zscore_peak_detector;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [15:0]                s_sample;
    logic                              s_block_start;
    logic                              m_valid;
    logic                              m_ready;
    logic signed [1:0]                 m_peak_signal;
    logic                              m_window_ready;
    logic                              cfg_we;
    logic [zpd_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [zpd_pkg::CFG_DATA_BITS-1:0] cfg_data;

    int fail_count;
    int pending;
    int burst_left;     // transfers left in the current sender burst
    int samples_sent;

    zscore_peak_detector u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_block_start  (s_block_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peak_signal  (m_peak_signal),
        .m_window_ready (m_window_ready),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    zpd_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_block_start  (s_block_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peak_signal  (m_peak_signal),
        .m_window_ready (m_window_ready),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: the stall pattern is redrawn periodically among always ready,
    // coin flip, and mostly stalled.
    int stall_mode;
    int stall_cnt;
    always @(negedge aclk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(2);
            stall_cnt  = 40;
        end
        stall_cnt--;
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(1);
            default: m_ready <= ($urandom_range(3) == 0);
        endcase
    end

    // One sample transfer. Valid stays high across a burst; between bursts it
    // usually drops for a random number of cycles.
    task automatic send_sample(input logic signed [15:0] smp, input logic bs);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_block_start <= bs;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        burst_left--;
        samples_sent++;
        @(negedge aclk);
    endtask

    // Wait until every predicted result has come back, then let the sequencer
    // settle before touching the registers.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(input zpd_pkg::cfg_reg_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[zpd_pkg::CFG_DATA_BITS-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input int len, input int thr, input int inf);
        drain();
        write_reg(zpd_pkg::REG_WINDOW_LENGTH, len);
        write_reg(zpd_pkg::REG_THRESHOLD, thr);
        write_reg(zpd_pkg::REG_INFLUENCE, inf);
    endtask

    initial begin
        int level;
        int smp;
        int spread;
        int len;
        int thr;
        int inf;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_sample      = '0;
        s_block_start = 1'b0;
        m_ready       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        stall_cnt     = 0;
        burst_left    = 0;
        samples_sent  = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // --- directed part ---
        // length 0 acts as 2, influence above one acts as one; no block start
        // yet, so the stream after reset is a single block
        configure(0, 256, 131071);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd100, 1'b0);            // warm-up ends here
        send_sample(16'sd100, 1'b0);            // zero deviation, equal to mean
        send_sample(16'sh7fff, 1'b0);           // zero spread, above: +1
        send_sample(-16'sh8000, 1'b0);          // far below: -1
        send_sample(-16'sh8000, 1'b1);          // new block, warm-up again
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(-16'sh8000, 1'b0);
        // odd influence so that blends land on half-LSB ties
        configure(3, 0, 32769);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(-16'sd5, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(-16'sd2, 1'b0);
        // length above the store size acts as the store size, widest threshold
        configure(127, 65535, 0);
        for (int i = 0; i < 66; i++)
            send_sample(16'(i[0] ? -7 : 7), 1'b0);
        // the length write alone clears the window
        configure(2, 1, 65536);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd6, 1'b0);
        send_sample(16'sd4, 1'b0);

        // --- random part: phases of blocks, mostly smooth signals with spikes ---
        for (int phase = 0; samples_sent < 400; phase++) begin
            case (phase)
                0: begin len = 2;  thr = 0;     inf = 65536; end
                1: begin len = 64; thr = 65535; inf = 0;     end
                default: begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(2, 12);
                    thr = ($urandom_range(5) == 0) ? $urandom_range(65535) : $urandom_range(1536);
                    inf = ($urandom_range(5) == 0) ? $urandom_range(131071) : $urandom_range(65536);
                end
            endcase
            configure(len, thr, inf);
            level  = $signed($urandom_range(65535)) - 32768;
            spread = $urandom_range(1, 2000);
            for (int n = 0; n < 40; n++) begin
                case ($urandom_range(19))
                    0:       smp = $urandom_range(65535) - 32768;   // noise
                    1, 2:    smp = level + (($urandom_range(1)) ? 20 : -20) * spread;
                    default: smp = level + $urandom_range(2 * spread) - spread;
                endcase
                if (smp > 32767)
                    smp = 32767;
                if (smp < -32768)
                    smp = -32768;
                level = level + $urandom_range(64) - 32;
                send_sample(16'(smp), n == 0 || $urandom_range(29) == 0);
            end
        end

        drain();
        if (fail_count == 0)
            $display("tb_zscore_peak_detector: PASS");
        else
            $display("tb_zscore_peak_detector: FAIL");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("tb_zscore_peak_detector: FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/zpd_pkg.sv
design/zpd_ram.sv
design/zpd_mul.sv
design/zscore_peak_detector.sv
design/zpd_checker.sv
verif/zpd_checker.sv
verif/tb_zscore_peak_detector.sv
